[sv/gwr_pkg.sv]
`timescale 1ns / 1ps

package gwr_pkg;

   // Pixel and grey widths.
   localparam int GREY_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int SUM_W      = 10;
   localparam int PROD_W     = 20;
   localparam int THRESH_W   = 8;

   // Division of the colour sum by 3 as a multiply by 683 / 2048.
   // The error stays below one third of a grey step for sums up to 765.
   localparam int GREY_DIVISOR = 3;
   localparam int GREY_RECIP   = 683;
   localparam int GREY_SHIFT   = 11;
   localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;

   // Window geometry.
   localparam int WIN_SIZE = GREY_DIVISOR;

   // Register port.
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int RESET_IMAGE_WIDTH  = 640;
   localparam int RESET_IMAGE_HEIGHT = 480;

   // Result queue.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef logic [GREY_W-1:0] grey_type;

   // Entry 0 is the top row of the window, entry 2 the bottom row.
   typedef grey_type [WIN_SIZE-1:0] column_type;

   typedef struct packed {
      logic                use_pre;
      logic [WIN_SIZE-1:0] row_valid;
   } judge_ctrl_type;

   typedef struct packed {
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic               is_pixel;
   } req_payload_type;

   typedef struct packed {
      logic edge_flag;
      logic frame_last;
   } rsp_payload_type;

endpackage

[sv/gwr_stream_if.sv]
`timescale 1ns / 1ps

interface gwr_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

[sv/gwr_line_store.sv]
`timescale 1ns / 1ps

module gwr_line_store #(
   parameter int DEPTH = 2048
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  gwr_pkg::grey_type          wr_grey,
   output gwr_pkg::grey_type          top_grey,
   output gwr_pkg::grey_type          mid_grey
);

   gwr_pkg::grey_type mem_a [DEPTH];
   gwr_pkg::grey_type mem_b [DEPTH];

   gwr_pkg::grey_type a_q_ff;
   gwr_pkg::grey_type b_q_ff;
   gwr_pkg::grey_type fwd_mid_ff;
   gwr_pkg::grey_type fwd_top_ff;
   logic              fwd_ff;
   logic              fwd_in;

   // A read that hits the column being written this cycle takes the new data.
   assign fwd_in   = wr_en && (wr_addr == rd_addr);
   assign mid_grey = fwd_ff ? fwd_mid_ff : a_q_ff;
   assign top_grey = fwd_ff ? fwd_top_ff : b_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_grey;
         mem_b[wr_addr] <= mid_grey;
      end
      if (rd_en) begin
         a_q_ff     <= mem_a[rd_addr];
         b_q_ff     <= mem_b[rd_addr];
         fwd_mid_ff <= wr_grey;
         fwd_top_ff <= mid_grey;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

endmodule

[sv/gwr_cell.sv]
`timescale 1ns / 1ps

module gwr_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  gwr_pkg::column_type     col_from,
   input  gwr_pkg::judge_ctrl_type judge,
   input  logic                    col_valid,
   output gwr_pkg::column_type     col_q,
   output gwr_pkg::grey_type       max_q,
   output gwr_pkg::grey_type       min_q
);

   gwr_pkg::column_type col_ff;
   gwr_pkg::column_type col_in;
   gwr_pkg::column_type src;
   gwr_pkg::grey_type   max_ff;
   gwr_pkg::grey_type   min_ff;
   gwr_pkg::grey_type   max_in;
   gwr_pkg::grey_type   min_in;

   assign col_in = shift_en ? col_from : col_ff;
   assign col_q  = col_ff;
   assign max_q  = max_ff;
   assign min_q  = min_ff;

   // Column extremes over the entries that lie inside the image.
   always_comb begin
      src    = judge.use_pre ? col_ff : col_from;
      max_in = '0;
      min_in = gwr_pkg::GREY_MAX;
      for (int j = 0; j < gwr_pkg::WIN_SIZE; j++) begin
         if (judge.row_valid[j] && col_valid) begin
            if (src[j] > max_in) begin
               max_in = src[j];
            end
            if (src[j] < min_in) begin
               min_in = src[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      min_ff <= min_in;
   end

endmodule

[sv/gwr_out_fifo.sv]
`timescale 1ns / 1ps

module gwr_out_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  gwr_pkg::rsp_payload_type         push_data,
   input  logic                             out_ready,
   output logic                             out_valid,
   output gwr_pkg::rsp_payload_type         out_data,
   output logic [gwr_pkg::OUT_CNT_W-1:0]    count
);

   gwr_pkg::rsp_payload_type entry_ff [gwr_pkg::OUT_DEPTH];

   logic [gwr_pkg::OUT_PTR_W-1:0] wr_ptr_ff;
   logic [gwr_pkg::OUT_PTR_W-1:0] rd_ptr_ff;
   logic [gwr_pkg::OUT_CNT_W-1:0] count_ff;
   logic                          pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == gwr_pkg::OUT_PTR_W'(gwr_pkg::OUT_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + gwr_pkg::OUT_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == gwr_pkg::OUT_PTR_W'(gwr_pkg::OUT_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + gwr_pkg::OUT_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + gwr_pkg::OUT_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - gwr_pkg::OUT_CNT_W'(1);
         end
      end
   end

endmodule

[sv/grey_window_range_edge_threshold.sv]
// A result is pushed after the stage 1 and stage 2 registers of the beat that completes its
// window and can be taken after the push; that beat arrives one row plus one pixel after it.
// Throughput: one beat per cycle, set by the line-store read/write pair at each column and
// the four-entry result queue, whose credit drops ready only while results wait unread.
// Reset (synchronous, active high) clears the counters, window cells and result queue and
// restores 640 x 480 with threshold 0; the line stores are not cleared and need no pass.
`timescale 1ns / 1ps

module grey_window_range_edge_threshold #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   gwr_stream_if.sink                        req_ch,
   gwr_stream_if.source                      rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [gwr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gwr_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // Column counter, effective width and height, result position and input row.
   // The row counter can run past the frame height during the drain and after a size
   // change, but never more than two rows past the result count.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int ROW_W  = POS_W + 2;
   localparam int AREA_W = WID_W + HGT_W;
   localparam int WIN    = gwr_pkg::WIN_SIZE;

   localparam int RESET_W = (gwr_pkg::RESET_IMAGE_WIDTH > MAX_WIDTH) ?
                            MAX_WIDTH : gwr_pkg::RESET_IMAGE_WIDTH;
   localparam int RESET_H = (gwr_pkg::RESET_IMAGE_HEIGHT > MAX_HEIGHT) ?
                            MAX_HEIGHT : gwr_pkg::RESET_IMAGE_HEIGHT;
   localparam int RESET_LAST = RESET_W * RESET_H - 1;

   // ---------------------------------------------------------------------------------------
   // Configuration registers. Sizes are clamped when they are written, and the index of
   // the final result of a frame is kept ready so that the pixel path needs no multiply.
   // ---------------------------------------------------------------------------------------
   logic [WID_W-1:0]             width_ff;
   logic [WID_W-1:0]             width_in;
   logic [HGT_W-1:0]             height_ff;
   logic [HGT_W-1:0]             height_in;
   logic [gwr_pkg::THRESH_W-1:0] thresh_ff;
   logic [gwr_pkg::THRESH_W-1:0] thresh_in;
   logic [POS_W-1:0]             last_pos_ff;
   logic [POS_W-1:0]             last_pos_in;
   logic [WID_W-1:0]             w_new;
   logic [HGT_W-1:0]             h_new;
   logic [AREA_W-1:0]            area;

   always_comb begin
      if (csr_write_data == '0) begin
         w_new = WID_W'(1);
      end else if (32'(csr_write_data) > 32'(MAX_WIDTH)) begin
         w_new = WID_W'(MAX_WIDTH);
      end else begin
         w_new = WID_W'(csr_write_data);
      end
      if (csr_write_data == '0) begin
         h_new = HGT_W'(1);
      end else if (32'(csr_write_data) > 32'(MAX_HEIGHT)) begin
         h_new = HGT_W'(MAX_HEIGHT);
      end else begin
         h_new = HGT_W'(csr_write_data);
      end

      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gwr_pkg::CSR_IMAGE_WIDTH: begin
               width_in = w_new;
            end
            gwr_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = h_new;
            end
            gwr_pkg::CSR_EDGE_THRESHOLD: begin
               thresh_in = csr_write_data[gwr_pkg::THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end

      area        = AREA_W'(width_in) * AREA_W'(height_in);
      last_pos_in = POS_W'(area - AREA_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WID_W'(RESET_W);
         height_ff   <= HGT_W'(RESET_H);
         thresh_ff   <= '0;
         last_pos_ff <= POS_W'(RESET_LAST);
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         thresh_ff   <= thresh_in;
         last_pos_ff <= last_pos_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 0: the accepted beat. Every control decision is made here from the counters
   // alone, so the colour data only feeds the grey conversion and the line-store write.
   // ---------------------------------------------------------------------------------------
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;

   logic                           take;
   logic                           wrap;
   logic [COL_W-1:0]               c_eff;
   logic [ROW_W-1:0]               r_eff;
   logic                           row_in_img;
   logic                           ignore;
   logic                           go;
   logic                           case_a;
   logic                           case_b;
   logic                           emit;
   logic                           last;
   logic                           row_end;
   logic [gwr_pkg::SUM_W-1:0]      color_sum;
   logic [gwr_pkg::PROD_W-1:0]     grey_prod;
   gwr_pkg::grey_type              grey_s0;
   logic [ROW_W:0]                 row_ext;
   logic [ROW_W:0]                 row_lo;
   logic [ROW_W:0]                 row_hi;
   logic [ROW_W:0]                 row_probe;
   logic [WIN-1:0]                 row_valid_s0;
   logic [WIN-1:0]                 col_valid_s0;
   logic [gwr_pkg::OUT_CNT_W-1:0]  credit_used;
   logic [gwr_pkg::OUT_CNT_W-1:0]  fifo_count;

   logic s1_pend;
   logic s2_pend;

   assign credit_used  = fifo_count + gwr_pkg::OUT_CNT_W'(s1_pend) +
                         gwr_pkg::OUT_CNT_W'(s2_pend);
   assign req_ch.ready = credit_used < gwr_pkg::OUT_CNT_W'(gwr_pkg::OUT_DEPTH);
   assign take         = req_ch.valid && req_ch.ready;

   // A column left beyond a narrowed width wraps before it is used.
   assign wrap       = WID_W'(col_ff) >= width_ff;
   assign c_eff      = wrap ? '0 : col_ff;
   assign r_eff      = row_ff + ROW_W'(wrap);
   assign row_in_img = r_eff < ROW_W'(height_ff);

   // A flush beat inside the frame is dropped; a pixel beat during the drain acts as flush.
   assign ignore = !req_ch.payload.is_pixel && row_in_img;
   assign go     = take && !ignore;

   // Case A judges the last pixel of an earlier row on the window before it moves;
   // case B judges the pixel up and to the left of the new one after the move.
   assign case_a  = (c_eff == '0) && (r_eff >= ROW_W'(2));
   assign case_b  = (c_eff != '0) && (r_eff >= ROW_W'(1));
   assign emit    = case_a || case_b;
   assign last    = pos_ff >= last_pos_ff;
   assign row_end = (WID_W'(c_eff) + WID_W'(1)) >= width_ff;

   always_comb begin
      color_sum = gwr_pkg::SUM_W'(req_ch.payload.blue) + gwr_pkg::SUM_W'(req_ch.payload.green) +
                  gwr_pkg::SUM_W'(req_ch.payload.red);
      grey_prod = gwr_pkg::PROD_W'(color_sum) * gwr_pkg::PROD_W'(gwr_pkg::GREY_RECIP);
      if (req_ch.payload.is_pixel && row_in_img) begin
         grey_s0 = grey_prod[gwr_pkg::GREY_SHIFT +: gwr_pkg::GREY_W];
      end else begin
         grey_s0 = '0;
      end
   end

   // Window row j lies at image row r_eff - 2 - case_a + j; it counts when inside the frame.
   always_comb begin
      row_ext = {1'b0, r_eff};
      row_lo  = (ROW_W+1)'(2) + (ROW_W+1)'(case_a);
      row_hi  = (ROW_W+1)'(height_ff) + (ROW_W+1)'(2) + (ROW_W+1)'(case_a);
      for (int j = 0; j < WIN; j++) begin
         row_probe       = row_ext + (ROW_W+1)'(j);
         row_valid_s0[j] = (row_probe >= row_lo) && (row_probe < row_hi);
      end
   end

   // Window column k counts when it lies inside the frame and next to the center column.
   // Before the move the center is the right column, so the left one is two away and
   // never counts; the right column always does.
   always_comb begin
      if (case_a) begin
         col_valid_s0[0] = 1'b0;
         col_valid_s0[1] = width_ff >= WID_W'(2);
         col_valid_s0[2] = 1'b1;
      end else begin
         col_valid_s0[0] = c_eff >= COL_W'(2);
         col_valid_s0[1] = 1'b1;
         col_valid_s0[2] = 1'b1;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      pos_in = pos_ff;
      if (take) begin
         col_in = c_eff;
         row_in = r_eff;
         if (!ignore) begin
            if (emit && last) begin
               // The final result of the frame: the next beat opens a new frame.
               col_in = '0;
               row_in = '0;
               pos_in = '0;
            end else begin
               if (emit) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               if (row_end) begin
                  col_in = '0;
                  row_in = r_eff + ROW_W'(1);
               end else begin
                  col_in = c_eff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         pos_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         pos_ff <= pos_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 1: the line stores return the two upper rows of the column, the stores are
   // written back, and the window cells shift one column to the left.
   // ---------------------------------------------------------------------------------------
   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   logic [COL_W-1:0]        s1_addr_ff;
   gwr_pkg::grey_type       s1_grey_ff;
   gwr_pkg::judge_ctrl_type s1_judge_ff;
   logic [WIN-1:0]          s1_col_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= go;
         s1_emit_ff  <= go && emit;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff            <= last;
      s1_addr_ff            <= c_eff;
      s1_grey_ff            <= grey_s0;
      s1_judge_ff.use_pre   <= case_a;
      s1_judge_ff.row_valid <= row_valid_s0;
      s1_col_valid_ff       <= col_valid_s0;
   end

   assign s1_pend = s1_emit_ff;

   gwr_pkg::grey_type   top_grey;
   gwr_pkg::grey_type   mid_grey;
   gwr_pkg::column_type new_col;
   gwr_pkg::column_type cell_col [WIN];
   gwr_pkg::grey_type   cell_max [WIN];
   gwr_pkg::grey_type   cell_min [WIN];

   gwr_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (go),
      .rd_addr  (c_eff),
      .wr_en    (s1_valid_ff),
      .wr_addr  (s1_addr_ff),
      .wr_grey  (s1_grey_ff),
      .top_grey (top_grey),
      .mid_grey (mid_grey)
   );

   always_comb begin
      new_col[0] = top_grey;
      new_col[1] = mid_grey;
      new_col[2] = s1_grey_ff;
   end

   // The rightmost cell takes the new column; each other cell takes its right neighbor's.
   for (genvar k = 0; k < WIN; k++) begin : g_cell
      gwr_pkg::column_type col_from;
      if (k == WIN - 1) begin : g_feed
         assign col_from = new_col;
      end else begin : g_link
         assign col_from = cell_col[k+1];
      end

      gwr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (s1_valid_ff),
         .col_from  (col_from),
         .judge     (s1_judge_ff),
         .col_valid (s1_col_valid_ff[k]),
         .col_q     (cell_col[k]),
         .max_q     (cell_max[k]),
         .min_q     (cell_min[k])
      );
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2: the column extremes are merged and the range is tested against the threshold.
   // With no valid entry the maximum stays below the minimum and the pixel is flat.
   // ---------------------------------------------------------------------------------------
   logic                     s2_emit_ff;
   logic                     s2_last_ff;
   gwr_pkg::grey_type        win_max;
   gwr_pkg::grey_type        win_min;
   gwr_pkg::grey_type        win_range;
   gwr_pkg::rsp_payload_type push_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_last_ff <= s1_last_ff;
   end

   assign s2_pend = s2_emit_ff;

   always_comb begin
      win_max = cell_max[0];
      win_min = cell_min[0];
      for (int k = 1; k < WIN; k++) begin
         if (cell_max[k] > win_max) begin
            win_max = cell_max[k];
         end
         if (cell_min[k] < win_min) begin
            win_min = cell_min[k];
         end
      end
      win_range            = win_max - win_min;
      push_data.edge_flag  = (win_max >= win_min) && (win_range > thresh_ff);
      push_data.frame_last = s2_last_ff;
   end

   gwr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_emit_ff),
      .push_data (push_data),
      .out_ready (rsp_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_data  (rsp_ch.payload),
      .count     (fifo_count)
   );

endmodule

[sv/gwr_checker.sv]
`timescale 1ns / 1ps

module gwr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input gwr_pkg::rsp_payload_type rsp_payload
);

   // Reset empties the result queue and reopens the input side.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty and ready after reset");

   // Input back-pressure only comes from results that wait unread.
   a_ready_backed: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result offered");

   // A result beat that is not taken stays offered with the same payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed or vanished");

   // A result beat that is stalled when an input beat is accepted is still offered on the next cycle.
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result lost after an accepted beat");

endmodule

bind grey_window_range_edge_threshold gwr_checker u_gwr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

[test/grey_window_range_edge_threshold_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the grey window range edge detector.
// Pixel beats go in through the request channel in raster order. A behavioral
// copy of the line stores and the 3x3 window runs alongside the design and
// queues the expected result beats. The monitor then compares every result beat
// against the oldest entry in that queue.
module grey_window_range_edge_threshold_test;

   localparam int LINE_DEPTH    = 2048;
   localparam int ROW_LIMIT     = 2048;
   localparam int CYCLE_LIMIT   = 500000;
   // The design pushes a result after the stage 1 and stage 2 registers of the completing
   // beat. This gives margin for beats that produce no result.
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BEATS  = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_write_enable;
   logic [gwr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [gwr_pkg::CSR_DATA_W-1:0]  csr_write_data;

   gwr_stream_if #(.payload_type(gwr_pkg::req_payload_type)) req_if ();
   gwr_stream_if #(.payload_type(gwr_pkg::rsp_payload_type)) rsp_if ();

   grey_window_range_edge_threshold u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Bench state. The initial block fills pixel_backlog and the driver empties it.
   gwr_pkg::req_payload_type pixel_backlog [$];
   gwr_pkg::rsp_payload_type edge_results_due [$];
   gwr_pkg::rsp_payload_type oldest_due;
   int  beats_pushed   = 0;
   int  beats_accepted = 0;
   int  frame_beats    = 0;
   int  mismatches     = 0;
   int  cycle_count    = 0;
   int  send_idle_pct  = 38;
   int  recv_stall_pct = 76;
   logic req_fired     = 1'b0;

   // Shadow copy of the design state. grey_two_up holds the row two above the
   // current one and grey_one_up holds the row directly above. The window is indexed
   // [row][column], and column 2 is the newest column.
   logic [gwr_pkg::GREY_W-1:0] grey_two_up [LINE_DEPTH] = '{default: '0};
   logic [gwr_pkg::GREY_W-1:0] grey_one_up [LINE_DEPTH] = '{default: '0};
   logic [gwr_pkg::GREY_W-1:0] window_grey [3][3] = '{default: '0};
   int col_in           = 0;
   int row_in           = 0;
   int results_in_frame = 0;
   logic [11:0] cfg_width     = 12'(gwr_pkg::RESET_IMAGE_WIDTH);
   logic [11:0] cfg_height    = 12'(gwr_pkg::RESET_IMAGE_HEIGHT);
   logic [7:0]  cfg_threshold = '0;

   function automatic int active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      return int'(cfg_width);
   endfunction

   function automatic int active_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > ROW_LIMIT) return ROW_LIMIT;
      return int'(cfg_height);
   endfunction

   // Window cell [i][k] sits at image row top_row+i and column left_col+k. Only
   // cells inside the image and next to the centre count, which cuts the window
   // at the borders.
   function automatic logic range_exceeds(input int centre_row, input int centre_col,
                                          input int top_row, input int left_col);
      int w, h, hi, lo, i, k, row, col;
      w  = active_width();
      h  = active_height();
      hi = 0;
      lo = 255;
      for (i = 0; i < 3; i++) begin
         for (k = 0; k < 3; k++) begin
            row = top_row + i;
            col = left_col + k;
            if (row >= 0 && row < h && col >= 0 && col < w &&
                row >= centre_row - 1 && row <= centre_row + 1 &&
                col >= centre_col - 1 && col <= centre_col + 1) begin
               if (window_grey[i][k] > hi) hi = window_grey[i][k];
               if (window_grey[i][k] < lo) lo = window_grey[i][k];
            end
         end
      end
      return (hi - lo) > int'(cfg_threshold);
   endfunction

   // Advance the shadow state by one accepted beat and queue the result it causes,
   // if there is one.
   task automatic predict_edge_results(input gwr_pkg::req_payload_type beat);
      int w, h, r, c, i, sum;
      logic [gwr_pkg::GREY_W-1:0] grey, top, mid;
      logic emit, flag, last;
      gwr_pkg::rsp_payload_type result;
      w    = active_width();
      h    = active_height();
      grey = '0;
      emit = 1'b0;
      flag = 1'b0;
      // A size change can leave the column past the new width. It wraps before use.
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      // A flush beat while pixels are still due is dropped with no effect.
      if (!beat.is_pixel && row_in < h) return;
      // During the drain, a pixel beat counts as a flush and its colour is lost.
      if (beat.is_pixel && row_in < h) begin
         sum  = beat.blue + beat.green + beat.red;
         grey = gwr_pkg::GREY_W'(sum / 3);
      end
      r = row_in;
      c = col_in;
      // At column 0, the last pixel of row r-2 is judged before the window shifts.
      if (c == 0 && r >= 2) begin
         flag = range_exceeds(r - 2, w - 1, r - 3, w - 3);
         emit = 1'b1;
      end
      top            = grey_two_up[c];
      mid            = grey_one_up[c];
      grey_two_up[c] = mid;
      grey_one_up[c] = grey;
      for (i = 0; i < 3; i++) begin
         window_grey[i][0] = window_grey[i][1];
         window_grey[i][1] = window_grey[i][2];
      end
      window_grey[0][2] = top;
      window_grey[1][2] = mid;
      window_grey[2][2] = grey;
      if (c >= 1 && r >= 1) begin
         flag = range_exceeds(r - 1, c - 1, r - 2, c - 2);
         emit = 1'b1;
      end
      if (emit) begin
         last              = results_in_frame >= w * h - 1;
         result.edge_flag  = flag;
         result.frame_last = last;
         edge_results_due.push_back(result);
         results_in_frame++;
         // After the final result of the frame, the next beat starts a new frame.
         if (last) begin
            col_in           = 0;
            row_in           = 0;
            results_in_frame = 0;
            return;
         end
      end
      if (c + 1 >= w) begin
         col_in = 0;
         row_in++;
      end else begin
         col_in++;
      end
   endtask

   // Request driver. Inputs change on the falling edge. A beat stays on the bus
   // until it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.payload <= pixel_backlog.pop_front();
            req_if.valid   <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result receiver. It applies back pressure at random, according to the current profile.
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor. Result beats are checked before the request beat of the same edge
   // is predicted. Because of the latency, a beat cannot cause a result on the edge
   // where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (edge_results_due.size() == 0) begin
               $error("result beat with nothing outstanding: edge_flag %0b frame_last %0b",
                      rsp_if.payload.edge_flag, rsp_if.payload.frame_last);
               mismatches++;
            end else begin
               oldest_due = edge_results_due.pop_front();
               if (rsp_if.payload.edge_flag !== oldest_due.edge_flag) begin
                  $error("edge_flag: expected %0b, actual %0b",
                         oldest_due.edge_flag, rsp_if.payload.edge_flag);
                  mismatches++;
               end
               if (rsp_if.payload.frame_last !== oldest_due.frame_last) begin
                  $error("frame_last: expected %0b, actual %0b",
                         oldest_due.frame_last, rsp_if.payload.frame_last);
                  mismatches++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            beats_accepted++;
            predict_edge_results(req_if.payload);
         end
      end
   end

   // Watchdog. This limit is far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL grey_window_range_edge_threshold");
         $finish;
      end
   end

   task automatic push_beat(input int b, input int g, input int r, input bit pixel);
      gwr_pkg::req_payload_type beat;
      beat.blue     = gwr_pkg::COLOR_W'(b);
      beat.green    = gwr_pkg::COLOR_W'(g);
      beat.red      = gwr_pkg::COLOR_W'(r);
      beat.is_pixel = pixel;
      pixel_backlog.push_back(beat);
      beats_pushed++;
   endtask

   // Noisy pixels cover every bit of the colour fields. Smooth pixels stay close
   // to one shade, so low thresholds give a mix of edge and flat results.
   task automatic push_random_pixel(input bit noisy_colour, input int shade);
      if (noisy_colour)
         push_beat($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b1);
      else
         push_beat(shade + $urandom_range(8), shade + $urandom_range(8),
                   shade + $urandom_range(8), 1'b1);
   endtask

   // One whole frame: w*h pixels, then w+1 drain beats. The broken variant scatters
   // ignored flushes among the pixels and puts some pixel beats into the drain.
   task automatic send_frame(input int w, input int h, input bit noisy_colour,
                             input bit broken);
      int shade;
      shade = $urandom_range(247);
      repeat (w * h) begin
         if (broken && $urandom_range(15) == 0)
            push_beat($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b0);
         push_random_pixel(noisy_colour, shade);
      end
      repeat (w + 1) begin
         if (broken && $urandom_range(7) == 0)
            push_random_pixel(1'b1, shade);
         else
            push_beat($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b0);
      end
      frame_beats += w * h + w + 1;
   endtask

   // Wait until every queued beat has been taken and every expected result has
   // arrived. The sender stays quiet while this happens.
   task automatic wait_idle();
      do @(negedge clock);
      while (beats_accepted != beats_pushed || edge_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Finish any partial frame with pixels and a drain, then wait until the design
   // is idle. If the design already sits at a frame start, only the wait is done.
   task automatic close_frame();
      int w, h, r, c, n;
      wait_idle();
      while (col_in != 0 || row_in != 0 || results_in_frame != 0) begin
         w = active_width();
         h = active_height();
         r = row_in;
         c = col_in;
         if (c >= w) begin
            c = 0;
            r++;
         end
         n = (r < h) ? (h - r) * w - c : 0;
         repeat (n) push_random_pixel(1'b0, 120);
         repeat (w + 1) push_beat(0, 0, 0, 1'b0);
         wait_idle();
      end
   endtask

   // Write all three registers on back-to-back edges. Call only when the design is idle.
   task automatic set_registers(input int w, input int h, input int thr);
      csr_write_enable <= 1'b1;
      csr_index        <= gwr_pkg::CSR_IMAGE_WIDTH;
      csr_write_data   <= gwr_pkg::CSR_DATA_W'(w);
      @(negedge clock);
      csr_index        <= gwr_pkg::CSR_IMAGE_HEIGHT;
      csr_write_data   <= gwr_pkg::CSR_DATA_W'(h);
      @(negedge clock);
      csr_index        <= gwr_pkg::CSR_EDGE_THRESHOLD;
      csr_write_data   <= gwr_pkg::CSR_DATA_W'(thr);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_width     = 12'(w);
      cfg_height    = 12'(h);
      cfg_threshold = 8'(thr);
   endtask

   initial begin
      int w, h, thr, stage, stop;
      csr_write_enable = 1'b0;
      csr_index        = gwr_pkg::CSR_IMAGE_WIDTH;
      csr_write_data   = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, 3x3 frame, threshold 0. It covers the colour extremes,
      // the rounding of the grey mean, a flush during the frame, a pixel during
      // the drain, and a flush at the start of the next frame.
      set_registers(3, 3, 0);
      push_beat(0, 0, 0, 1'b1);
      push_beat(255, 255, 255, 1'b1);
      push_beat(255, 0, 0, 1'b1);
      push_beat(0, 0, 0, 1'b0);
      push_beat(0, 255, 0, 1'b1);
      push_beat(0, 0, 255, 1'b1);
      push_beat(255, 255, 254, 1'b1);
      push_beat(1, 1, 1, 1'b1);
      push_beat(85, 85, 85, 1'b1);
      push_beat(2, 0, 0, 1'b1);
      push_beat(0, 0, 0, 1'b0);
      push_beat(170, 85, 255, 1'b1);
      push_beat(0, 0, 0, 1'b0);
      push_beat(0, 0, 0, 1'b0);
      push_beat(0, 0, 0, 1'b0);
      close_frame();

      // Smallest frame with the largest threshold. The result must be flat.
      set_registers(1, 1, 255);
      push_beat(255, 255, 255, 1'b1);
      push_beat(0, 0, 0, 1'b0);
      push_beat(0, 0, 0, 1'b0);
      close_frame();

      // Width shrinks mid-frame. The column is past the new width, so it wraps
      // and the row advances before the next beat is used.
      set_registers(4, 3, 17);
      repeat (6) push_random_pixel(1'b1, 0);
      wait_idle();
      set_registers(2, 3, 17);
      close_frame();

      // Random part. Each stage uses a different idle and stall profile, and each
      // stage starts from an idle design. Most frames are small, and a few are
      // wide single rows.
      frame_beats = 0;
      for (stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               send_idle_pct  = 38;
               recv_stall_pct = 76;
            end
            1: begin
               send_idle_pct  = 76;
               recv_stall_pct = 38;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         stop = (stage + 1) * RANDOM_BEATS / 3;
         while (frame_beats < stop) begin
            case ($urandom_range(19))
               0:       w = $urandom_range(64, 200);
               1, 2, 3: w = $urandom_range(9, 40);
               default: w = $urandom_range(1, 8);
            endcase
            h = (w > 40) ? 1 : $urandom_range(1, 6);
            case ($urandom_range(3))
               0:       thr = 0;
               1:       thr = 255;
               2:       thr = $urandom_range(12);
               default: thr = $urandom_range(255);
            endcase
            set_registers(w, h, thr);
            // Frames with the same setting follow each other with no pause.
            repeat ($urandom_range(1, 3))
               send_frame(w, h, 1'($urandom_range(1)), $urandom_range(3) == 0);
            close_frame();
         end
      end

      if (mismatches == 0)
         $display("PASS grey_window_range_edge_threshold");
      else
         $display("FAIL grey_window_range_edge_threshold");
      $finish;
   end

endmodule
